>>> rtl/core/wlf_pkg.sv
// ----------------------------------------------------------------------------
// wlf_pkg: shared types and codes for the weighted line fit core
// Payload structs for both channels, the queued point command and status codes.
// ----------------------------------------------------------------------------
package wlf_pkg;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic        [31:0] x_error;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] intercept;
    logic signed [31:0] slope;
    logic        [31:0] intercept_error;
    logic        [31:0] slope_error;
    logic        [2:0]  fit_status;
  } out_item_t;

  // point as handed from the front to the back
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] e;
    logic        ok;    // point is to be accumulated
    logic        last;
  } cmd_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO_DET = 3'd1;
  localparam logic [2:0] ST_VAR_ICPT = 3'd2;
  localparam logic [2:0] ST_VAR_SLP  = 3'd3;
  localparam logic [2:0] ST_BAD      = 3'd4;

endpackage

>>> rtl/core/wlf_fifo.sv
// ----------------------------------------------------------------------------
// wlf_fifo: small register queue
// Decouples point classification from the arithmetic back end.
// ----------------------------------------------------------------------------
module wlf_fifo #(
  parameter int WIDTH = 98,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

>>> rtl/core/wlf_front.sv
// ----------------------------------------------------------------------------
// wlf_front: point intake
// Accepts points, flags zero errors and overlong runs, tracks the run length.
// ----------------------------------------------------------------------------
module wlf_front import wlf_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          ok;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign ok       = (count_r < CW'(MAX_POINTS)) && (in_data.x_error != '0);

  assign q_cmd.x    = in_data.x_value;
  assign q_cmd.y    = in_data.y_value;
  assign q_cmd.e    = in_data.x_error;
  assign q_cmd.ok   = ok;
  assign q_cmd.last = in_data.last_point;

  always_comb begin
    count_nxt = count_r;
    if (q_push) begin
      if (in_data.last_point) begin
        count_nxt = '0;
      end else if (ok) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/core/wlf_mul.sv
// ----------------------------------------------------------------------------
// wlf_mul: unsigned 64x64 multiplier
// One 32x32 partial product per cycle, four partial products per result.
// ----------------------------------------------------------------------------
module wlf_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [1:0]   k_r;
  logic         busy_r, done_r;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  assign a_part = k_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_part = k_r[0] ? b_r[63:32] : b_r[31:0];
  assign pp     = a_part * b_part;

  always_comb begin
    case ({1'b0, k_r[1]} + {1'b0, k_r[0]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= !start && busy_r && (k_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/core/wlf_div.sv
// ----------------------------------------------------------------------------
// wlf_div: restoring divider, floor(num * 2^sh / den) to 64 bits
// One quotient bit per cycle from bit index top down to zero; flags saturation.
// ----------------------------------------------------------------------------
module wlf_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [6:0]   sh,
  input  logic [7:0]   top,
  input  logic [127:0] den,
  output logic         done,
  output logic [63:0]  quo,
  output logic         sat
);

  logic [127:0] n_r, d_r, rem_r;
  logic [6:0]   sh_r;
  logic [7:0]   i_r, j;
  logic [63:0]  q_r;
  logic         busy_r, done_r, sat_r;
  logic         nbit, carry, take;
  logic [127:0] rem_sh;

  assign j      = i_r - {1'b0, sh_r};
  assign nbit   = (i_r >= {1'b0, sh_r}) ? n_r[j[6:0]] : 1'b0;
  assign carry  = rem_r[127];
  assign rem_sh = {rem_r[126:0], nbit};
  assign take   = carry || (rem_sh >= d_r);

  assign done = done_r;
  assign quo  = q_r;
  assign sat  = sat_r;

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      sh_r  <= sh;
      i_r   <= top;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      if (q_r[63]) begin
        q_r   <= '1;
        sat_r <= 1'b1;
      end else begin
        rem_r <= take ? rem_sh - d_r : rem_sh;
        q_r   <= {q_r[62:0], take};
        i_r   <= i_r - 8'd1;
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (q_r[63] || i_r == 8'd0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (q_r[63] || i_r == 8'd0)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/wlf_back.sv
// ----------------------------------------------------------------------------
// wlf_back: accumulate and solve
// Weights and accumulates queued points; on the last point solves the fit.
// ----------------------------------------------------------------------------
module wlf_back import wlf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int         F3    = 3 * FRAC_BITS;
  localparam logic [6:0] SH1   = 7'(FRAC_BITS);
  localparam logic [6:0] SH3   = 7'(F3);
  localparam logic [7:0] TOP1  = 8'(127 + FRAC_BITS);
  localparam logic [7:0] TOP3  = 8'(127 + F3);
  localparam logic [7:0] TOPW  = 8'(F3);
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_WDIV, S_PSTART, S_PMUL, S_ACC, S_TAIL,
    S_SSTART, S_SMUL, S_SCOMB, S_STATUS, S_DSTART, S_DIV, S_SQRT, S_OUT
  } state_t;

  state_t state_r;
  cmd_t   cmd_r;
  logic [2:0] pidx_r;
  logic [1:0] didx_r;
  logic       neg_r, bad_r;

  logic [63:0]  sw_r, swx_r, swxx_r, swy_r, swxy_r;
  logic [63:0]  w_r, wx_r, wxx_r, wy_r, wxy_r;
  logic [127:0] sp_r, t_r, delta_r, na_r, nb_r;
  logic [63:0]  sq_v_r, sq_res_r, sq_bit_r;

  logic         mul_start_r, div_start_r;
  logic [63:0]  mul_a_r, mul_b_r;
  logic [127:0] div_num_r, div_den_r;
  logic [6:0]   div_sh_r;
  logic [7:0]   div_top_r;
  logic         mul_done, div_done, div_sat;
  logic [127:0] mul_prod;
  logic [63:0]  div_quo;

  logic         out_valid_r;
  out_item_t    out_r;
  logic [31:0]  ra_r, rb_r, rea_r, reb_r;
  logic [2:0]   stat_r;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [127:0] mag128(input logic [127:0] v);
    return v[127] ? (~v + 128'd1) : v;
  endfunction

  function automatic logic add_ovf(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    return (a[63] == b[63]) && (r[63] != a[63]);
  endfunction

  wlf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  wlf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .sh    (div_sh_r),
    .top   (div_top_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  // fixed-point product, floored, with range check
  logic [127:0] ms_q, ms_q1;
  logic         ms_rnd, ms_ovf;
  logic [63:0]  ms_val;
  assign ms_q   = mul_prod >> FRAC_BITS;
  assign ms_rnd = neg_r && (mul_prod[FRAC_BITS-1:0] != '0);
  assign ms_q1  = ms_q + {127'd0, ms_rnd};
  assign ms_ovf = (ms_q1[127:64] != '0) ||
                  (neg_r ? (ms_q1[63:0] > MIN64) : ms_q1[63]);
  assign ms_val = neg_r ? (~ms_q1[63:0] + 64'd1) : ms_q1[63:0];

  logic [63:0] xs, ys, xm, ym;
  assign xs = {{32{cmd_r.x[31]}}, cmd_r.x};
  assign ys = {{32{cmd_r.y[31]}}, cmd_r.y};
  assign xm = mag64(xs);
  assign ym = mag64(ys);

  logic acc_ovf;
  assign acc_ovf = add_ovf(sw_r, w_r) || add_ovf(swx_r, wx_r) || add_ovf(swxx_r, wxx_r) ||
                   add_ovf(swy_r, wy_r) || add_ovf(swxy_r, wxy_r);

  // solve operands
  logic [63:0] sop_a, sop_b;
  always_comb begin
    case (pidx_r)
      3'd0:    begin sop_a = sw_r;   sop_b = swxx_r; end
      3'd1:    begin sop_a = swx_r;  sop_b = swx_r;  end
      3'd2:    begin sop_a = swxx_r; sop_b = swy_r;  end
      3'd3:    begin sop_a = swx_r;  sop_b = swxy_r; end
      3'd4:    begin sop_a = sw_r;   sop_b = swxy_r; end
      default: begin sop_a = swx_r;  sop_b = swy_r;  end
    endcase
  end

  logic var_a_bad, var_b_bad;
  assign var_a_bad = (swxx_r == '0) || (swxx_r[63] != delta_r[127]);
  assign var_b_bad = (sw_r == '0) || (sw_r[63] != delta_r[127]);

  // ratio saturation
  logic        r_neg;
  logic [63:0] q_neg;
  logic [31:0] ratio;
  assign r_neg = (didx_r[0] ? nb_r[127] : na_r[127]) != delta_r[127];
  assign q_neg = ~div_quo + 64'd1;
  always_comb begin
    if (r_neg) begin
      ratio = (div_sat || div_quo > 64'h8000_0000) ? 32'h8000_0000 : q_neg[31:0];
    end else begin
      ratio = (div_sat || div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
    end
  end

  logic [63:0] sq_try;
  logic        sq_ge;
  assign sq_try = sq_res_r + sq_bit_r;
  assign sq_ge  = sq_v_r >= sq_try;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      bad_r       <= 1'b0;
      pidx_r      <= '0;
      didx_r      <= '0;
      sw_r        <= '0;
      swx_r       <= '0;
      swxx_r      <= '0;
      swy_r       <= '0;
      swxy_r      <= '0;
    end else begin
      mul_start_r <= ((state_r == S_IDLE) && !q_empty && q_cmd.ok) ||
                     (state_r == S_PSTART) || (state_r == S_SSTART);
      div_start_r <= ((state_r == S_SQ) && mul_done) || (state_r == S_DSTART);
      out_valid_r <= (out_valid_r && !out_ready) ||
                     ((state_r == S_OUT) && (!out_valid_r || out_ready));
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r <= q_cmd;
            if (q_cmd.ok) begin
              mul_a_r <= {32'd0, q_cmd.e};
              mul_b_r <= {32'd0, q_cmd.e};
              state_r <= S_SQ;
            end else begin
              bad_r   <= 1'b1;
              state_r <= S_TAIL;
            end
          end
        end
        S_SQ: begin
          if (mul_done) begin
            div_num_r <= 128'd1;
            div_sh_r  <= SH3;
            div_top_r <= TOPW;
            div_den_r <= {64'd0, mul_prod[63:0]};
            state_r   <= S_WDIV;
          end
        end
        S_WDIV: begin
          if (div_done) begin
            if (div_sat || div_quo[63]) begin
              bad_r   <= 1'b1;
              state_r <= S_TAIL;
            end else begin
              w_r     <= div_quo;
              pidx_r  <= '0;
              state_r <= S_PSTART;
            end
          end
        end
        S_PSTART: begin
          case (pidx_r)
            3'd0: begin mul_a_r <= w_r;        mul_b_r <= xm; neg_r <= cmd_r.x[31]; end
            3'd1: begin
              mul_a_r <= mag64(wx_r); mul_b_r <= xm; neg_r <= wx_r[63] ^ cmd_r.x[31];
            end
            3'd2: begin mul_a_r <= w_r;        mul_b_r <= ym; neg_r <= cmd_r.y[31]; end
            default: begin
              mul_a_r <= mag64(wx_r); mul_b_r <= ym; neg_r <= wx_r[63] ^ cmd_r.y[31];
            end
          endcase
          state_r <= S_PMUL;
        end
        S_PMUL: begin
          if (mul_done) begin
            case (pidx_r)
              3'd0:    wx_r  <= ms_val;
              3'd1:    wxx_r <= ms_val;
              3'd2:    wy_r  <= ms_val;
              default: wxy_r <= ms_val;
            endcase
            if (ms_ovf) begin
              bad_r   <= 1'b1;
              state_r <= S_TAIL;
            end else if (pidx_r == 3'd3) begin
              state_r <= S_ACC;
            end else begin
              pidx_r  <= pidx_r + 3'd1;
              state_r <= S_PSTART;
            end
          end
        end
        S_ACC: begin
          if (acc_ovf) begin
            bad_r <= 1'b1;
          end else begin
            sw_r   <= sw_r + w_r;
            swx_r  <= swx_r + wx_r;
            swxx_r <= swxx_r + wxx_r;
            swy_r  <= swy_r + wy_r;
            swxy_r <= swxy_r + wxy_r;
          end
          state_r <= S_TAIL;
        end
        S_TAIL: begin
          pidx_r  <= '0;
          state_r <= cmd_r.last ? S_SSTART : S_IDLE;
        end
        S_SSTART: begin
          mul_a_r <= mag64(sop_a);
          mul_b_r <= mag64(sop_b);
          neg_r   <= sop_a[63] ^ sop_b[63];
          state_r <= S_SMUL;
        end
        S_SMUL: begin
          if (mul_done) begin
            sp_r    <= neg_r ? (~mul_prod + 128'd1) : mul_prod;
            state_r <= S_SCOMB;
          end
        end
        S_SCOMB: begin
          case (pidx_r)
            3'd1:    delta_r <= t_r - sp_r;
            3'd3:    na_r    <= t_r - sp_r;
            3'd5:    nb_r    <= t_r - sp_r;
            default: t_r     <= sp_r;
          endcase
          if (pidx_r == 3'd5) begin
            state_r <= S_STATUS;
          end else begin
            pidx_r  <= pidx_r + 3'd1;
            state_r <= S_SSTART;
          end
        end
        S_STATUS: begin
          ra_r   <= '0;
          rb_r   <= '0;
          rea_r  <= '0;
          reb_r  <= '0;
          didx_r <= '0;
          if (bad_r) begin
            stat_r  <= ST_BAD;
            state_r <= S_OUT;
          end else if (delta_r == '0) begin
            stat_r  <= ST_ZERO_DET;
            state_r <= S_OUT;
          end else if (var_a_bad) begin
            stat_r  <= ST_VAR_ICPT;
            state_r <= S_OUT;
          end else if (var_b_bad) begin
            stat_r  <= ST_VAR_SLP;
            state_r <= S_OUT;
          end else begin
            stat_r  <= ST_OK;
            state_r <= S_DSTART;
          end
        end
        S_DSTART: begin
          case (didx_r)
            2'd0: begin div_num_r <= mag128(na_r); div_sh_r <= SH1; div_top_r <= TOP1; end
            2'd1: begin div_num_r <= mag128(nb_r); div_sh_r <= SH1; div_top_r <= TOP1; end
            2'd2: begin
              div_num_r <= {64'd0, mag64(swxx_r)}; div_sh_r <= SH3; div_top_r <= TOP3;
            end
            default: begin
              div_num_r <= {64'd0, mag64(sw_r)}; div_sh_r <= SH3; div_top_r <= TOP3;
            end
          endcase
          div_den_r <= mag128(delta_r);
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (!didx_r[1]) begin
              if (didx_r[0]) begin
                rb_r <= ratio;
              end else begin
                ra_r <= ratio;
              end
              didx_r  <= didx_r + 2'd1;
              state_r <= S_DSTART;
            end else if (div_sat) begin
              if (didx_r[0]) begin
                reb_r   <= 32'hFFFF_FFFF;
                state_r <= S_OUT;
              end else begin
                rea_r   <= 32'hFFFF_FFFF;
                didx_r  <= didx_r + 2'd1;
                state_r <= S_DSTART;
              end
            end else begin
              sq_v_r   <= div_quo;
              sq_res_r <= '0;
              sq_bit_r <= 64'h4000_0000_0000_0000;
              state_r  <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (sq_bit_r == '0) begin
            if (didx_r[0]) begin
              reb_r   <= sq_res_r[31:0];
              state_r <= S_OUT;
            end else begin
              rea_r   <= sq_res_r[31:0];
              didx_r  <= didx_r + 2'd1;
              state_r <= S_DSTART;
            end
          end else begin
            if (sq_ge) begin
              sq_v_r   <= sq_v_r - sq_try;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.intercept       <= ra_r;
            out_r.slope           <= rb_r;
            out_r.intercept_error <= rea_r;
            out_r.slope_error     <= reb_r;
            out_r.fit_status      <= stat_r;
            sw_r    <= '0;
            swx_r   <= '0;
            swxx_r  <= '0;
            swy_r   <= '0;
            swxy_r  <= '0;
            bad_r   <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/weighted_line_fit_core.sv
// Per point: a bit-serial weight divide (1/err^2) and five passes of the shared
// multiplier; one point at a time.
// Last point adds the solve: six products, two ratio divides and two error divides
// plus bit-serial square roots.
// Up to 4 points queue ahead of the back end; input stalls only when it is full.
// Synchronous reset clears sums, run count, queue and result valid flag.
// ----------------------------------------------------------------------------
// weighted_line_fit_core: weighted least-squares straight-line fit
// Front classifies points, a queue feeds the accumulate and solve back end.
// ----------------------------------------------------------------------------
module weighted_line_fit_core import wlf_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int MAX_POINTS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_in, q_out;
  logic [$bits(cmd_t)-1:0] q_rd;

  wlf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  wlf_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign q_out = cmd_t'(q_rd);

  wlf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for weighted_line_fit_core
// Streams runs of weighted points through the core and checks each fit
// against a bit-exact fixed-point predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import wlf_pkg::*;

  localparam int FRAC       = 16;
  localparam int RUN_LIMIT  = 256;
  localparam int CYCLE_CAP  = 10000000;
  localparam int LONG_HOLD  = 3000;

  typedef logic signed [129:0] wide_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  weighted_line_fit_core #(.FRAC_BITS(FRAC), .MAX_POINTS(RUN_LIMIT)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // floor(a*b / 2^F), flags a result outside signed 64 bits
  function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        inout bit ovf);
    wide_t p;
    wide_t lo_lim;
    wide_t hi_lim;
    p = wide_t'(a) * wide_t'(b);
    p = p >>> FRAC;
    lo_lim = -(wide_t'(1) <<< 63);
    hi_lim = (wide_t'(1) <<< 63) - 1;
    if (p < lo_lim || p > hi_lim) ovf = 1;
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] checked_sum(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     inout bit ovf);
    logic signed [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) ovf = 1;
    return r;
  endfunction

  function automatic logic [129:0] magnitude(input wide_t v);
    return v < 0 ? -v : v;
  endfunction

  // floor(|n| * 2^s / |d|); sat when the quotient needs more than 64 bits
  function automatic logic [63:0] scaled_quotient(input wide_t n, input int s,
                                                  input wide_t d, output bit sat);
    logic [199:0] num;
    logic [199:0] q;
    num = 200'(magnitude(n)) << s;
    q = num / 200'(magnitude(d));
    sat = (q[199:64] != 0);
    return q[63:0];
  endfunction

  function automatic logic [31:0] fit_ratio(input wide_t num, input wide_t delta);
    bit sat;
    logic [63:0] q;
    q = scaled_quotient(num, FRAC, delta, sat);
    if ((num < 0) != (delta < 0)) begin
      if (sat || q > 64'h8000_0000) return 32'h8000_0000;
      return 32'(-q);
    end
    if (sat || q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic logic [31:0] fit_error(input logic signed [63:0] s, input wide_t delta);
    bit sat;
    logic [63:0] v;
    logic [32:0] lo;
    logic [32:0] hi;
    logic [32:0] mid;
    v = scaled_quotient(wide_t'(s), 3 * FRAC, delta, sat);
    if (sat) return 32'hFFFF_FFFF;
    // largest r with r*r <= v
    lo = 0;
    hi = 33'h1_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (66'(mid) * 66'(mid) <= 66'(v)) lo = mid;
      else hi = mid;
    end
    return lo[31:0];
  endfunction

  function automatic bit variance_bad(input logic signed [63:0] s, input wide_t delta);
    return s == 0 || (s < 0) != (delta < 0);
  endfunction

  class fit_scoreboard;
    logic signed [63:0] sw, swx, swxx, swy, swxy;
    bit                 tainted;
    int                 run_points;
    out_item_t          fits_due[$];
    int                 errors;
    int                 points_in;
    int                 fits_out;
    int                 status_hits[5];

    function void clear_run();
      sw = 0; swx = 0; swxx = 0; swy = 0; swxy = 0;
      tainted = 0;
      run_points = 0;
    endfunction

    function void note_input(in_item_t p);
      logic [63:0]        ee;
      logic [63:0]        w;
      logic signed [63:0] x, y, wx, wxx, wy, wxy, s0, s1, s2, s3, s4;
      bit                 ovf;
      wide_t              delta;
      out_item_t          r;
      points_in++;
      if (run_points >= RUN_LIMIT || p.x_error == 0) begin
        tainted = 1;
      end else begin
        ovf = 0;
        ee = 64'(p.x_error) * 64'(p.x_error);
        w = 64'((130'(1) << (3 * FRAC)) / 130'(ee));
        x = p.x_value;
        y = p.y_value;
        wx  = scaled_product($signed(w), x, ovf);
        wxx = scaled_product(wx, x, ovf);
        wy  = scaled_product($signed(w), y, ovf);
        wxy = scaled_product(wx, y, ovf);
        s0 = checked_sum(sw, $signed(w), ovf);
        s1 = checked_sum(swx, wx, ovf);
        s2 = checked_sum(swxx, wxx, ovf);
        s3 = checked_sum(swy, wy, ovf);
        s4 = checked_sum(swxy, wxy, ovf);
        if (ovf) tainted = 1;
        else begin
          sw = s0; swx = s1; swxx = s2; swy = s3; swxy = s4;
        end
        run_points++;
      end
      if (!p.last_point) return;
      r = '0;
      delta = wide_t'(sw) * wide_t'(swxx) - wide_t'(swx) * wide_t'(swx);
      if (tainted) r.fit_status = ST_BAD;
      else if (delta == 0) r.fit_status = ST_ZERO_DET;
      else if (variance_bad(swxx, delta)) r.fit_status = ST_VAR_ICPT;
      else if (variance_bad(sw, delta)) r.fit_status = ST_VAR_SLP;
      else begin
        r.fit_status = ST_OK;
        r.intercept = fit_ratio(wide_t'(swxx) * wide_t'(swy) - wide_t'(swx) * wide_t'(swxy),
                                delta);
        r.slope = fit_ratio(wide_t'(sw) * wide_t'(swxy) - wide_t'(swx) * wide_t'(swy), delta);
        r.intercept_error = fit_error(swxx, delta);
        r.slope_error = fit_error(sw, delta);
      end
      status_hits[r.fit_status]++;
      fits_due.push_back(r);
      clear_run();
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      fits_out++;
      if (fits_due.size() == 0) begin
        $display("%0t: unexpected fit result %h", $time, got);
        errors++;
        return;
      end
      want = fits_due.pop_front();
      if (got.intercept !== want.intercept) begin
        $display("%0t: intercept expected %h actual %h", $time, want.intercept, got.intercept);
        errors++;
      end
      if (got.slope !== want.slope) begin
        $display("%0t: slope expected %h actual %h", $time, want.slope, got.slope);
        errors++;
      end
      if (got.intercept_error !== want.intercept_error) begin
        $display("%0t: intercept_error expected %h actual %h", $time,
                 want.intercept_error, got.intercept_error);
        errors++;
      end
      if (got.slope_error !== want.slope_error) begin
        $display("%0t: slope_error expected %h actual %h", $time,
                 want.slope_error, got.slope_error);
        errors++;
      end
      if (got.fit_status !== want.fit_status) begin
        $display("%0t: fit_status expected %0d actual %0d", $time,
                 want.fit_status, got.fit_status);
        errors++;
      end
    endfunction
  endclass

  fit_scoreboard sb;
  int            cycles;
  bit            burst_mode;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  function automatic int idle_len();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_point(input in_item_t p);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_xy(input int x, input int y, input int unsigned e, input bit last);
    in_item_t p;
    p.x_value = x;
    p.y_value = y;
    p.x_error = e;
    p.last_point = last;
    send_point(p);
  endtask

  // flavor 0: realistic hits, 1: any bit pattern, 2: small integers
  function automatic in_item_t make_point(input int flavor, input bit last);
    in_item_t p;
    case (flavor)
      0: begin
        p.x_value = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        p.y_value = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
        p.x_error = $urandom_range(32'h0000_1000, 32'h0010_0000);
      end
      1: begin
        p.x_value = $urandom;
        p.y_value = $urandom;
        p.x_error = $urandom;
      end
      default: begin
        p.x_value = ($signed($urandom_range(0, 40)) - 20) <<< FRAC;
        p.y_value = ($signed($urandom_range(0, 40)) - 20) <<< FRAC;
        p.x_error = $urandom_range(1, 4) << FRAC;
      end
    endcase
    if ($urandom_range(0, 99) < 2) p.x_error = 0;
    p.last_point = last;
    return p;
  endfunction

  task automatic send_run(input int n, input int flavor);
    for (int i = 0; i < n; i++) send_point(make_point(flavor, i == n - 1));
  endtask

  // result side: random stalls plus one long hold-off so the input backs up
  initial begin
    bit held;
    int r;
    held = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      r = idle_len();
      if (!held && sb.fits_out >= 15) begin
        held = 1;
        r = LONG_HOLD;
      end
      if (r > 0) begin
        out_ready <= 1'b0;
        repeat (r) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int wait_cycles;
    sb = new();
    sb.clear_run();
    cycles = 0;
    burst_mode = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point at x = 0: determinant vanishes
    send_xy(0, 32'sh0001_0000, 32'h0001_0000, 1);
    // clean two-point line
    send_xy(-32'sh0001_0000, 0, 32'h0001_0000, 0);
    send_xy(32'sh0001_0000, 32'sh0002_0000, 32'h0001_0000, 1);
    // zero error inside a run
    send_xy(32'sh0001_0000, 32'sh0001_0000, 32'h0001_0000, 0);
    send_xy(32'sh0002_0000, 32'sh0003_0000, 0, 0);
    send_xy(32'sh0003_0000, 32'sh0002_0000, 32'h0001_0000, 1);
    // product overflow: largest x with the smallest error
    send_xy(32'sh7FFF_FFFF, 0, 32'h0000_0001, 0);
    send_xy(0, 0, 32'h0001_0000, 1);
    // field extremes
    send_xy(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_xy(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 0);
    send_xy(0, -1, 32'h8000_0000, 1);
    // zero error on the last point alone
    send_xy(32'sh0001_0000, 32'sh0001_0000, 0, 1);
    // steep and flat lines, saturating ratio
    send_xy(0, 32'sh7FFF_0000, 32'h0000_0100, 0);
    send_xy(32'sh0000_0001, 32'sh8000_0000, 32'h0000_0100, 1);
    send_xy(32'sh0005_0000, 32'sh0001_0000, 32'h0002_0000, 0);
    send_xy(32'sh0005_0000, 32'sh0004_0000, 32'h0002_0000, 1);

    // over-long run: points past the limit taint the fit
    for (int i = 0; i <= RUN_LIMIT + 3; i++)
      send_xy(($signed(i % 7) - 3) <<< FRAC, i <<< 8, 32'h0001_0000, i == RUN_LIMIT + 3);

    while (sb.points_in < 1700) begin
      if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_run($urandom_range(2, 8), 0);
        6, 7:             send_run($urandom_range(1, 6), 2);
        8:                send_run($urandom_range(1, 4), 1);
        default:          send_run($urandom_range(9, 30), 0);
      endcase
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.fits_due.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (1500) @(posedge clk);
    if (sb.fits_due.size() != 0) begin
      $display("%0d fit results never arrived", sb.fits_due.size());
      sb.errors++;
    end

    $display("Sent %0d points, checked %0d fits", sb.points_in, sb.fits_out);
    $display("Status mix ok/zero-det/icpt-var/slope-var/bad: %0d/%0d/%0d/%0d/%0d",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
